// File: src/spi_port_transaction_engine_assert.svh
// Assertion macros for the SPI port transaction engine checker.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef SPI_PORT_TRANSACTION_ENGINE_ASSERT_SVH
`define SPI_PORT_TRANSACTION_ENGINE_ASSERT_SVH

// Same-cycle implication
`define SPTE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPTE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spte_pkg.sv
// ----------------------------------------------------------------------------
// spte_pkg
// Types and constants shared by the SPI port transaction engine.
// ----------------------------------------------------------------------------
`default_nettype none

package spte_pkg;

  localparam int SELECT_LINES = 16;
  localparam int LINE_W       = 4;
  localparam int LIMIT_W      = 16;

  localparam logic [15:0] RETRY_LIMIT_RESET = 16'd100;

  localparam logic [7:0] BYTE_IDLE   = 8'hFF;
  localparam logic [7:0] PORT_MASK   = 8'h7F;
  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [7:0] HIGH_NIBBLE = 8'hF0;
  localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
  localparam logic [3:0] MAX_BYTES   = 4'd8;

  // item actions
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TYPE  = 2'd2;
  localparam logic [1:0] ACT_RX    = 2'd3;

  // completion codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SYNC     = 2'd1;
  localparam logic [1:0] ST_TIMEOUT  = 2'd2;
  localparam logic [1:0] ST_DEV_ERR  = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SYNC  = 3'd1,
    PH_CMD   = 3'd2,
    PH_WDATA = 3'd3,
    PH_POLL  = 3'd4,
    PH_READ  = 3'd5
  } phase_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  select_line;
    logic [6:0]  port;
    logic [3:0]  data_bytes;
    logic [63:0] write_data;
    logic [7:0]  rx_byte;
  } in_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        select_active;
    logic [3:0]  active_line;
    logic        done_res;
    logic [1:0]  status;
    logic [63:0] read_data;
    logic [3:0]  type_code;
  } out_t;

  typedef struct packed {
    phase_t              phase;
    logic [1:0]          operation;
    logic [LINE_W-1:0]   line_in_use;
    logic [6:0]          saved_port;
    logic [3:0]          byte_total;
    logic [3:0]          byte_index;
    logic [LIMIT_W-1:0]  attempt_count;
    logic [63:0]         data_shift;
  } state_t;

endpackage

`default_nettype wire

// File: src/spi_port_transaction_engine.sv
// ----------------------------------------------------------------------------
// spi_port_transaction_engine
// SPI master transaction sequencer for a port-addressed peripheral protocol.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes start items (read,
//   write, type query) and "byte received" items carrying the byte from the
//   exchange just completed. Every item yields exactly one transaction on the
//   result channel (out_valid/out_ready/out_data): the next byte to shift
//   out, the select line state and, on the last step, the completion code
//   with read data or the type code.
//   cfg_we/cfg_wdata write the retry limit; write it only while idle.
//   An accepted item waits in the input register, then the step logic moves
//   it into the output register once that is free. Throughput: one item per
//   cycle while the receiver takes results, set by the two registers.
//   Reset (rst_n low at a clock edge) empties both registers, returns the
//   sequencer to idle and sets the retry limit to 100.
//   When the receiver stalls, the result holds, the input register still
//   takes one more item, and in_ready then drops until the output drains.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_port_transaction_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  spte_pkg::in_t    in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output spte_pkg::out_t   out_data,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);

  logic              in_v_r;
  spte_pkg::in_t     in_r;
  logic              out_v_r;
  spte_pkg::out_t    out_r;
  spte_pkg::state_t  st_r;
  spte_pkg::state_t  st_nxt;
  spte_pkg::out_t    res_nxt;
  logic [15:0]       retry_limit_r;
  logic              advance;

  // Move the held item into the output register when it is free
  assign advance  = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  spte_step u_step (
    .st          (st_r),
    .item        (in_r),
    .retry_limit (retry_limit_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  // Hold retry limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= spte_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_we) begin
      retry_limit_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Advance sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: spte_pkg::PH_IDLE, default: '0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: src/spte_step.sv
// ----------------------------------------------------------------------------
// spte_step
// Next-state and result logic for one item of the transaction sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module spte_step (
  input  spte_pkg::state_t  st,
  input  spte_pkg::in_t     item,
  input  logic [15:0]       retry_limit,
  output spte_pkg::state_t  st_nxt,
  output spte_pkg::out_t    res
);

  logic [15:0] limit;
  logic [15:0] attempt_inc;
  logic [3:0]  index_inc;
  logic [2:0]  wr_idx;
  logic [7:0]  wr_byte;
  logic [63:0] rx_placed;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        done;
  logic [1:0]  status;
  logic [63:0] read_data;
  logic [3:0]  type_code;

  // Zero limit acts as one
  assign limit       = (retry_limit == 16'd0) ? 16'd1 : retry_limit;
  assign attempt_inc = st.attempt_count + 16'd1;
  assign index_inc   = st.byte_index + 4'd1;

  // Pick write byte: first byte in command phase, next byte in data phase
  assign wr_idx  = (st.phase == spte_pkg::PH_CMD) ? 3'd0 : index_inc[2:0];
  assign wr_byte = st.data_shift[{wr_idx, 3'b000} +: 8];

  // Place received byte at its lane
  assign rx_placed = 64'(item.rx_byte) << {st.byte_index[2:0], 3'b000};

  always_comb begin
    st_nxt    = st;
    tx_valid  = 1'b0;
    tx_byte   = 8'd0;
    done      = 1'b0;
    status    = spte_pkg::ST_OK;
    read_data = 64'd0;
    type_code = 4'd0;

    if (item.action != spte_pkg::ACT_RX) begin
      // Open a transaction only when idle
      if (st.phase == spte_pkg::PH_IDLE) begin
        st_nxt.operation     = item.action;
        st_nxt.line_in_use   = spte_pkg::LINE_W'(32'(item.select_line)
                                                 % spte_pkg::SELECT_LINES);
        st_nxt.saved_port    = item.port;
        st_nxt.byte_total    = (item.data_bytes > spte_pkg::MAX_BYTES) ?
                               spte_pkg::MAX_BYTES : item.data_bytes;
        st_nxt.byte_index    = 4'd0;
        st_nxt.attempt_count = 16'd0;
        st_nxt.data_shift    = (item.action == spte_pkg::ACT_WRITE) ?
                               item.write_data : 64'd0;
        st_nxt.phase         = spte_pkg::PH_SYNC;
        tx_valid             = 1'b1;
        tx_byte              = spte_pkg::BYTE_IDLE;
      end
    end else begin
      case (st.phase)
        spte_pkg::PH_IDLE: begin
          st_nxt.phase = spte_pkg::PH_IDLE;
        end
        spte_pkg::PH_SYNC: begin
          if (item.rx_byte == spte_pkg::BYTE_IDLE) begin
            st_nxt.phase = spte_pkg::PH_CMD;
            tx_valid     = 1'b1;
            tx_byte      = (st.operation == spte_pkg::ACT_WRITE) ?
                           ({1'b0, st.saved_port} | spte_pkg::WRITE_FLAG) :
                           ({1'b0, st.saved_port} & spte_pkg::PORT_MASK);
          end else if (st.attempt_count >= limit) begin
            st_nxt.phase = spte_pkg::PH_IDLE;
            done         = 1'b1;
            status       = spte_pkg::ST_SYNC;
          end else begin
            st_nxt.attempt_count = attempt_inc;
            tx_valid             = 1'b1;
            tx_byte              = spte_pkg::BYTE_IDLE;
          end
        end
        spte_pkg::PH_CMD: begin
          st_nxt.byte_index = 4'd0;
          tx_valid          = 1'b1;
          if (st.operation == spte_pkg::ACT_WRITE && st.byte_total != 4'd0) begin
            st_nxt.phase = spte_pkg::PH_WDATA;
            tx_byte      = wr_byte;
          end else begin
            st_nxt.phase         = spte_pkg::PH_POLL;
            st_nxt.attempt_count = 16'd0;
            tx_byte              = spte_pkg::BYTE_IDLE;
          end
        end
        spte_pkg::PH_WDATA: begin
          st_nxt.byte_index = index_inc;
          tx_valid          = 1'b1;
          if (index_inc < st.byte_total) begin
            tx_byte = wr_byte;
          end else begin
            st_nxt.phase         = spte_pkg::PH_POLL;
            st_nxt.attempt_count = 16'd0;
            tx_byte              = spte_pkg::BYTE_IDLE;
          end
        end
        spte_pkg::PH_POLL: begin
          st_nxt.attempt_count = attempt_inc;
          if (attempt_inc >= limit) begin
            st_nxt.phase = spte_pkg::PH_IDLE;
            done         = 1'b1;
            status       = spte_pkg::ST_TIMEOUT;
          end else if (item.rx_byte == spte_pkg::BYTE_IDLE) begin
            tx_valid = 1'b1;
            tx_byte  = spte_pkg::BYTE_IDLE;
          end else if ((item.rx_byte & spte_pkg::HIGH_NIBBLE) != 8'd0) begin
            st_nxt.phase = spte_pkg::PH_IDLE;
            done         = 1'b1;
            status       = spte_pkg::ST_DEV_ERR;
          end else if (st.operation == spte_pkg::ACT_READ &&
                       st.byte_total != 4'd0) begin
            st_nxt.phase      = spte_pkg::PH_READ;
            st_nxt.byte_index = 4'd0;
            st_nxt.data_shift = 64'd0;
            tx_valid          = 1'b1;
            tx_byte           = spte_pkg::BYTE_IDLE;
          end else begin
            st_nxt.phase = spte_pkg::PH_IDLE;
            done         = 1'b1;
            if (st.operation == spte_pkg::ACT_TYPE) begin
              type_code = 4'(item.rx_byte & spte_pkg::LOW_NIBBLE);
            end
          end
        end
        spte_pkg::PH_READ: begin
          st_nxt.data_shift = st.data_shift | rx_placed;
          st_nxt.byte_index = index_inc;
          if (index_inc >= st.byte_total) begin
            st_nxt.phase = spte_pkg::PH_IDLE;
            done         = 1'b1;
            read_data    = st.data_shift | rx_placed;
          end else begin
            tx_valid = 1'b1;
            tx_byte  = spte_pkg::BYTE_IDLE;
          end
        end
        default: begin
          st_nxt.phase = spte_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // Assemble result
  always_comb begin
    res.tx_valid      = tx_valid;
    res.tx_byte       = tx_byte;
    res.select_active = (st_nxt.phase != spte_pkg::PH_IDLE);
    res.active_line   = 4'(st_nxt.line_in_use);
    res.done_res      = done;
    res.status        = status;
    res.read_data     = read_data;
    res.type_code     = type_code;
  end

endmodule

`default_nettype wire

// File: src/spte_checker.sv
// ----------------------------------------------------------------------------
// spte_checker
// Port-level checks for the SPI port transaction engine, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_port_transaction_engine_assert.svh"

module spte_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input spte_pkg::out_t  out_data
);

  // Stalled result holds
  `SPTE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "stalled result changed")

  // Item accepted into an empty output shows a result via the input and output registers
  `SPTE_ASSERT_NEXT(a_latency, in_valid && in_ready && !out_valid,
                    ##1 out_valid, "result missing after accept")

  // Failure releases the select line
  `SPTE_ASSERT_NOW(a_fail_release, out_valid && out_data.status != spte_pkg::ST_OK,
                   out_data.done_res && !out_data.select_active, "failure without release")

  // Completion never sends another byte
  `SPTE_ASSERT_NOW(a_done_quiet, out_valid && out_data.done_res,
                   !out_data.select_active && !out_data.tx_valid, "done while still active")

  // No byte without an exchange
  `SPTE_ASSERT_NOW(a_tx_zero, out_valid && !out_data.tx_valid,
                   out_data.tx_byte == 8'd0, "tx byte without exchange")

endmodule

bind spi_port_transaction_engine spte_checker u_spte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
